// ===== rtl/ipv4dq_pkg.sv =====
// Package for the IPv4 dotted-quad parser: types, character codes and
// character-class helper functions. It depends on nothing else.
package ipv4dq_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;

    localparam int VALUE_W = 9;
    localparam int PROD_W  = 13;
    localparam int DIGIT_W = 5;
    localparam logic [VALUE_W-1:0] SAT_VALUE = 9'd256;
    localparam logic [VALUE_W-1:0] MAX_OCTET = 9'd255;
    localparam logic [DIGIT_W-1:0] NO_DIGIT  = 5'd16;

    typedef enum logic [4:0] {
        PH_LEAD  = 5'b00001,
        PH_PRE   = 5'b00010,
        PH_SIGN  = 5'b00100,
        PH_NUM   = 5'b01000,
        PH_TRAIL = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        BASE_NONE = 2'd0,
        BASE_DEC  = 2'd1,
        BASE_OCT  = 2'd2,
        BASE_HEX  = 2'd3
    } base_t;

    typedef enum logic [1:0] {
        PFX_NONE = 2'd0,
        PFX_ZERO = 2'd1,
        PFX_ZX   = 2'd2,
        PFX_BODY = 2'd3
    } pfx_t;

    typedef struct packed {
        logic       accepted;
        logic [7:0] octet_first;
        logic [7:0] octet_second;
        logic [7:0] octet_third;
        logic [7:0] octet_fourth;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (is_dec(c)) begin
            t = c - CH_ZERO;
        end
        else if ((c >= CH_LA) && (c <= CH_LF)) begin
            t = c - CH_LA + 8'd10;
        end
        else if ((c >= CH_UA) && (c <= CH_UF)) begin
            t = c - CH_UA + 8'd10;
        end
        else begin
            t = 8'(NO_DIGIT);
        end
        return t[DIGIT_W-1:0];
    endfunction

endpackage

// ===== rtl/ipv4_dotted_quad_parser_unit.sv =====
// Top level of the IPv4 dotted-quad parser: input byte register, parse core,
// result register. Uses ipv4dq_pkg, ipv4dq_parse and ipv4dq_out.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------
//   input    | in_valid / in_stall  | text_byte[7:0]
//   result   | out_valid / out_stall| accepted, octet_first..octet_fourth
//
// One byte per cycle while in_stall is low; the parse state updates in a
// single pass. Each NUL's result is registered after the byte register.
// in_stall rises only while a NUL waits in the input register and the
// previous result is still held by out_stall.
// Reset clears the handshake and parse control state; no warm-up is needed.
module ipv4_dotted_quad_parser_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       accepted,
    output logic [7:0] octet_first,
    output logic [7:0] octet_second,
    output logic [7:0] octet_third,
    output logic [7:0] octet_fourth
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       step;
    logic       load_in;
    logic       res_valid;
    ipv4dq_pkg::result_t res;
    ipv4dq_pkg::result_t res_out;

    // hold a NUL while the previous result is still waiting
    assign step     = in_valid_reg &&
                      !((byte_reg == ipv4dq_pkg::CH_NUL) && out_valid && out_stall);
    assign in_stall = in_valid_reg && !step;
    assign load_in  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        byte_next     = byte_reg;
        if (load_in) begin
            in_valid_next = 1'b1;
            byte_next     = text_byte;
        end
        else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    ipv4dq_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .char_in   (byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    ipv4dq_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .res_out   (res_out)
    );

    assign accepted     = res_out.accepted;
    assign octet_first  = res_out.octet_first;
    assign octet_second = res_out.octet_second;
    assign octet_third  = res_out.octet_third;
    assign octet_fourth = res_out.octet_fourth;

endmodule

// ===== rtl/ipv4dq_parse.sv =====
// Parse state and per-byte next-state logic of the dotted-quad parser.
// Uses ipv4dq_pkg; produces one result transaction per NUL byte.
module ipv4dq_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          char_in,
    output logic                res_valid,
    output ipv4dq_pkg::result_t res
);

    ipv4dq_pkg::phase_t phase_reg, phase_next;
    ipv4dq_pkg::base_t  base_reg, base_next;
    ipv4dq_pkg::pfx_t   pfx_reg, pfx_next;
    logic [1:0]                      idx_reg, idx_next;
    logic [ipv4dq_pkg::VALUE_W-1:0]  val_reg, val_next;
    logic minus_reg, minus_next;
    logic prelude_reg, prelude_next;
    logic wild_reg, wild_next;
    logic fail_reg, fail_next;
    logic [7:0] oct0_reg, oct0_next;
    logic [7:0] oct1_reg, oct1_next;
    logic [7:0] oct2_reg, oct2_next;

    logic [ipv4dq_pkg::DIGIT_W-1:0] dig;
    logic [ipv4dq_pkg::DIGIT_W-1:0] radix;
    logic [ipv4dq_pkg::PROD_W-1:0]  prod;
    logic [ipv4dq_pkg::PROD_W-1:0]  ext;
    logic value_bad;
    logic pre_act, end_act, begin_act, next_act;
    logic ok;
    logic [7:0] last;

    always_comb
    begin
        dig   = ipv4dq_pkg::digit_of(char_in);
        ext   = ipv4dq_pkg::PROD_W'(val_reg);
        case (base_reg)
            ipv4dq_pkg::BASE_HEX:
            begin
                radix = 5'd16;
                prod  = (ext << 4) + ipv4dq_pkg::PROD_W'(dig);
            end
            ipv4dq_pkg::BASE_OCT:
            begin
                radix = 5'd8;
                prod  = (ext << 3) + ipv4dq_pkg::PROD_W'(dig);
            end
            default:
            begin
                radix = 5'd10;
                prod  = (ext << 3) + (ext << 1) + ipv4dq_pkg::PROD_W'(dig);
            end
        endcase
        value_bad = (val_reg > ipv4dq_pkg::MAX_OCTET) || (minus_reg && (val_reg != '0));
    end

    always_comb
    begin
        phase_next   = phase_reg;
        base_next    = base_reg;
        pfx_next     = pfx_reg;
        idx_next     = idx_reg;
        val_next     = val_reg;
        minus_next   = minus_reg;
        prelude_next = prelude_reg;
        wild_next    = wild_reg;
        fail_next    = fail_reg;
        oct0_next    = oct0_reg;
        oct1_next    = oct1_reg;
        oct2_next    = oct2_reg;
        pre_act      = 1'b0;
        end_act      = 1'b0;
        begin_act    = 1'b0;
        next_act     = 1'b0;
        ok           = 1'b0;
        last         = 8'd0;
        res_valid    = 1'b0;
        res          = '0;

        if (step && (char_in != ipv4dq_pkg::CH_NUL)) begin
            if (!wild_reg && !fail_reg) begin
                case (phase_reg)
                    ipv4dq_pkg::PH_LEAD:
                    begin
                        if (ipv4dq_pkg::is_space(char_in)) begin
                            phase_next = ipv4dq_pkg::PH_LEAD;
                        end
                        else if (char_in == ipv4dq_pkg::CH_STAR) begin
                            wild_next = 1'b1;
                        end
                        else begin
                            phase_next = ipv4dq_pkg::PH_PRE;
                            pre_act    = 1'b1;
                        end
                    end
                    ipv4dq_pkg::PH_PRE:
                    begin
                        pre_act = 1'b1;
                    end
                    ipv4dq_pkg::PH_SIGN:
                    begin
                        if (ipv4dq_pkg::is_dec(char_in)) begin
                            begin_act = 1'b1;
                        end
                        else begin
                            fail_next = 1'b1;
                        end
                    end
                    ipv4dq_pkg::PH_NUM:
                    begin
                        if (pfx_reg == ipv4dq_pkg::PFX_ZERO) begin
                            if ((char_in == ipv4dq_pkg::CH_LX) ||
                                (char_in == ipv4dq_pkg::CH_UX)) begin
                                pfx_next = ipv4dq_pkg::PFX_ZX;
                            end
                            else if (dig < 5'd8) begin
                                base_next = ipv4dq_pkg::BASE_OCT;
                                pfx_next  = ipv4dq_pkg::PFX_BODY;
                                val_next  = ipv4dq_pkg::VALUE_W'(dig);
                            end
                            else begin
                                end_act = 1'b1;
                            end
                        end
                        else if (pfx_reg == ipv4dq_pkg::PFX_ZX) begin
                            if (dig < ipv4dq_pkg::NO_DIGIT) begin
                                base_next = ipv4dq_pkg::BASE_HEX;
                                pfx_next  = ipv4dq_pkg::PFX_BODY;
                                val_next  = ipv4dq_pkg::VALUE_W'(dig);
                            end
                            else begin
                                end_act = 1'b1;
                            end
                        end
                        else if (dig < radix) begin
                            if (prod > ipv4dq_pkg::PROD_W'(ipv4dq_pkg::SAT_VALUE)) begin
                                val_next = ipv4dq_pkg::SAT_VALUE;
                            end
                            else begin
                                val_next = prod[ipv4dq_pkg::VALUE_W-1:0];
                            end
                        end
                        else begin
                            end_act = 1'b1;
                        end
                    end
                    ipv4dq_pkg::PH_TRAIL:
                    begin
                        if (!ipv4dq_pkg::is_space(char_in)) begin
                            fail_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        fail_next = 1'b1;
                    end
                endcase

                if (pre_act) begin
                    if (ipv4dq_pkg::is_space(char_in)) begin
                        prelude_next = 1'b1;
                    end
                    else if ((char_in == ipv4dq_pkg::CH_PLUS) ||
                             (char_in == ipv4dq_pkg::CH_MINUS)) begin
                        minus_next = (char_in == ipv4dq_pkg::CH_MINUS);
                        phase_next = ipv4dq_pkg::PH_SIGN;
                    end
                    else if (ipv4dq_pkg::is_dec(char_in)) begin
                        begin_act = 1'b1;
                    end
                    else if ((idx_reg != 2'd3) && !prelude_reg &&
                             (char_in == ipv4dq_pkg::CH_DOT)) begin
                        next_act = 1'b1;
                    end
                    else begin
                        fail_next = 1'b1;
                    end
                end

                if (end_act) begin
                    if ((pfx_reg == ipv4dq_pkg::PFX_ZX) || value_bad) begin
                        fail_next = 1'b1;
                    end
                    else if (idx_reg != 2'd3) begin
                        if (char_in == ipv4dq_pkg::CH_DOT) begin
                            next_act = 1'b1;
                        end
                        else begin
                            fail_next = 1'b1;
                        end
                    end
                    else if (ipv4dq_pkg::is_space(char_in)) begin
                        phase_next = ipv4dq_pkg::PH_TRAIL;
                    end
                    else begin
                        fail_next = 1'b1;
                    end
                end

                if (begin_act) begin
                    phase_next = ipv4dq_pkg::PH_NUM;
                    if (char_in == ipv4dq_pkg::CH_ZERO) begin
                        pfx_next  = ipv4dq_pkg::PFX_ZERO;
                        base_next = ipv4dq_pkg::BASE_NONE;
                        val_next  = '0;
                    end
                    else begin
                        pfx_next  = ipv4dq_pkg::PFX_BODY;
                        base_next = ipv4dq_pkg::BASE_DEC;
                        val_next  = ipv4dq_pkg::VALUE_W'(dig);
                    end
                end

                if (next_act) begin
                    case (idx_reg)
                        2'd0:    oct0_next = val_reg[7:0];
                        2'd1:    oct1_next = val_reg[7:0];
                        default: oct2_next = val_reg[7:0];
                    endcase
                    idx_next     = idx_reg + 2'd1;
                    phase_next   = ipv4dq_pkg::PH_PRE;
                    val_next     = '0;
                    base_next    = ipv4dq_pkg::BASE_NONE;
                    pfx_next     = ipv4dq_pkg::PFX_NONE;
                    minus_next   = 1'b0;
                    prelude_next = 1'b0;
                end
            end
        end
        else if (step) begin
            if (wild_reg) begin
                ok = 1'b1;
            end
            else if (!fail_reg && (idx_reg == 2'd3)) begin
                case (phase_reg)
                    ipv4dq_pkg::PH_PRE:
                    begin
                        ok = 1'b1;
                    end
                    ipv4dq_pkg::PH_NUM:
                    begin
                        ok   = (pfx_reg != ipv4dq_pkg::PFX_ZX) && !value_bad;
                        last = val_reg[7:0];
                    end
                    ipv4dq_pkg::PH_TRAIL:
                    begin
                        ok   = 1'b1;
                        last = val_reg[7:0];
                    end
                    default:
                    begin
                        ok = 1'b0;
                    end
                endcase
            end
            res_valid = 1'b1;
            res.accepted = ok;
            if (ok && !wild_reg) begin
                res.octet_first  = oct0_reg;
                res.octet_second = oct1_reg;
                res.octet_third  = oct2_reg;
                res.octet_fourth = last;
            end
            phase_next   = ipv4dq_pkg::PH_LEAD;
            idx_next     = 2'd0;
            val_next     = '0;
            base_next    = ipv4dq_pkg::BASE_NONE;
            pfx_next     = ipv4dq_pkg::PFX_NONE;
            minus_next   = 1'b0;
            prelude_next = 1'b0;
            wild_next    = 1'b0;
            fail_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= ipv4dq_pkg::PH_LEAD;
            base_reg    <= ipv4dq_pkg::BASE_NONE;
            pfx_reg     <= ipv4dq_pkg::PFX_NONE;
            idx_reg     <= 2'd0;
            val_reg     <= '0;
            minus_reg   <= 1'b0;
            prelude_reg <= 1'b0;
            wild_reg    <= 1'b0;
            fail_reg    <= 1'b0;
        end
        else begin
            phase_reg   <= phase_next;
            base_reg    <= base_next;
            pfx_reg     <= pfx_next;
            idx_reg     <= idx_next;
            val_reg     <= val_next;
            minus_reg   <= minus_next;
            prelude_reg <= prelude_next;
            wild_reg    <= wild_next;
            fail_reg    <= fail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oct0_reg <= oct0_next;
        oct1_reg <= oct1_next;
        oct2_reg <= oct2_next;
    end

endmodule

// ===== rtl/ipv4dq_out.sv =====
// Result register of the dotted-quad parser with valid/stall handshake.
// Uses ipv4dq_pkg::result_t.
module ipv4dq_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ipv4dq_pkg::result_t res,
    input  logic                out_stall,
    output logic                out_valid,
    output ipv4dq_pkg::result_t res_out
);

    logic                valid_reg, valid_next;
    ipv4dq_pkg::result_t res_reg, res_next;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (load) begin
            valid_next = 1'b1;
            res_next   = res;
        end
        else if (!out_stall) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

// ===== rtl/ipv4dq_checker.sv =====
// Port-level checker for ipv4_dotted_quad_parser_unit, attached by bind.
// Depends only on the top level's ports.
module ipv4dq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       accepted,
    input logic [7:0] octet_first,
    input logic [7:0] octet_second,
    input logic [7:0] octet_third,
    input logic [7:0] octet_fourth
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(accepted) &&
        $stable(octet_first) && $stable(octet_second) &&
        $stable(octet_third) && $stable(octet_fourth))
        else $error("result changed while stalled");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> (octet_first == 8'd0) && (octet_second == 8'd0) &&
        (octet_third == 8'd0) && (octet_fourth == 8'd0))
        else $error("rejected transaction carries non-zero octets");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && in_valid |=> !in_valid || !in_stall || (out_valid && out_stall))
        else $error("input stall outlived the result stall");

endmodule

bind ipv4_dotted_quad_parser_unit ipv4dq_checker u_ipv4dq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .octet_first  (octet_first),
    .octet_second (octet_second),
    .octet_third  (octet_third),
    .octet_fourth (octet_fourth)
);

// ===== tb/sv/ipv4_dotted_quad_parser_unit_tb.sv =====
// Self-checking testbench for ipv4_dotted_quad_parser_unit: streams text strings
// byte by byte and checks each result against an in-bench dotted-quad parser.
// Depends on ipv4dq_pkg and the parser RTL only.
module ipv4_dotted_quad_parser_unit_tb;

    logic       clk;
    logic       rst_n;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] text_byte = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       accepted;
    logic [7:0] octet_first;
    logic [7:0] octet_second;
    logic [7:0] octet_third;
    logic [7:0] octet_fourth;

    ipv4_dotted_quad_parser_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .octet_first  (octet_first),
        .octet_second (octet_second),
        .octet_third  (octet_third),
        .octet_fourth (octet_fourth)
    );

    logic [7:0] pending_q [$];
    logic [7:0] draft_q [$];
    ipv4dq_pkg::result_t expected_q [$];

    int         errors      = 0;
    int         send_idle   = 0;
    int         recv_idle   = 0;
    int         bytes_taken = 0;
    int         hold_at     = 32'h7fff_ffff;
    int         hold_left   = 0;
    bit         hold_done   = 1'b0;
    logic       in_taken    = 1'b0;

    ipv4dq_pkg::phase_t ps_phase;
    logic [1:0] ps_index;
    logic [8:0] ps_value;
    ipv4dq_pkg::base_t  ps_base;
    ipv4dq_pkg::pfx_t   ps_pfx;
    logic       ps_minus;
    logic       ps_prelude;
    logic       ps_wild;
    logic       ps_failed;
    logic [7:0] ps_octets [0:2];

    function automatic bit blank_char(input logic [7:0] c);
        return (c == ipv4dq_pkg::CH_SPACE) ||
               ((c >= ipv4dq_pkg::CH_TAB) && (c <= ipv4dq_pkg::CH_CR));
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if ((c >= ipv4dq_pkg::CH_ZERO) && (c <= ipv4dq_pkg::CH_NINE))
            return c - ipv4dq_pkg::CH_ZERO;
        if ((c >= ipv4dq_pkg::CH_LA) && (c <= ipv4dq_pkg::CH_LF))
            return c - ipv4dq_pkg::CH_LA + 10;
        if ((c >= ipv4dq_pkg::CH_UA) && (c <= ipv4dq_pkg::CH_UF))
            return c - ipv4dq_pkg::CH_UA + 10;
        return 16;
    endfunction

    function automatic bit value_rejects();
        return (ps_value > 9'd255) || (ps_minus && (ps_value != 9'd0));
    endfunction

    task automatic field_clear();
        ps_value   = 9'd0;
        ps_base    = ipv4dq_pkg::BASE_NONE;
        ps_pfx     = ipv4dq_pkg::PFX_NONE;
        ps_minus   = 1'b0;
        ps_prelude = 1'b0;
    endtask

    task automatic parser_restart();
        ps_phase  = ipv4dq_pkg::PH_LEAD;
        ps_index  = 2'd0;
        field_clear();
        for (int i = 0; i < 3; i++)
            ps_octets[i] = 8'd0;
        ps_wild   = 1'b0;
        ps_failed = 1'b0;
    endtask

    task automatic close_field();
        ps_octets[ps_index] = ps_value[7:0];
        ps_index = ps_index + 2'd1;
        ps_phase = ipv4dq_pkg::PH_PRE;
        field_clear();
    endtask

    task automatic start_digits(input logic [7:0] c);
        ps_phase = ipv4dq_pkg::PH_NUM;
        if (c == ipv4dq_pkg::CH_ZERO)
        begin
            ps_pfx   = ipv4dq_pkg::PFX_ZERO;
            ps_base  = ipv4dq_pkg::BASE_NONE;
            ps_value = 9'd0;
        end
        else
        begin
            ps_pfx   = ipv4dq_pkg::PFX_BODY;
            ps_base  = ipv4dq_pkg::BASE_DEC;
            ps_value = 9'(c - ipv4dq_pkg::CH_ZERO);
        end
    endtask

    task automatic prelude_char(input logic [7:0] c);
        if (blank_char(c))
            ps_prelude = 1'b1;
        else if ((c == ipv4dq_pkg::CH_PLUS) || (c == ipv4dq_pkg::CH_MINUS))
        begin
            ps_minus = (c == ipv4dq_pkg::CH_MINUS);
            ps_phase = ipv4dq_pkg::PH_SIGN;
        end
        else if ((c >= ipv4dq_pkg::CH_ZERO) && (c <= ipv4dq_pkg::CH_NINE))
            start_digits(c);
        else if ((ps_index < 2'd3) && !ps_prelude && (c == ipv4dq_pkg::CH_DOT))
        begin
            ps_value = 9'd0;
            close_field();
        end
        else
            ps_failed = 1'b1;
    endtask

    task automatic finish_number(input logic [7:0] c);
        if ((ps_pfx == ipv4dq_pkg::PFX_ZX) || value_rejects())
            ps_failed = 1'b1;
        else if (ps_index < 2'd3)
        begin
            if (c == ipv4dq_pkg::CH_DOT)
                close_field();
            else
                ps_failed = 1'b1;
        end
        else if (blank_char(c))
            ps_phase = ipv4dq_pkg::PH_TRAIL;
        else
            ps_failed = 1'b1;
    endtask

    task automatic parse_byte(input logic [7:0] c);
        ipv4dq_pkg::result_t res;
        logic       ok;
        logic [7:0] last;
        int         d;
        int         radix;
        int         v;
        if (c != ipv4dq_pkg::CH_NUL)
        begin
            if (ps_wild || ps_failed)
                return;
            case (ps_phase)
                ipv4dq_pkg::PH_LEAD:
                begin
                    if (c == ipv4dq_pkg::CH_STAR)
                        ps_wild = 1'b1;
                    else if (!blank_char(c))
                    begin
                        ps_phase = ipv4dq_pkg::PH_PRE;
                        prelude_char(c);
                    end
                end
                ipv4dq_pkg::PH_PRE:
                    prelude_char(c);
                ipv4dq_pkg::PH_SIGN:
                begin
                    if ((c >= ipv4dq_pkg::CH_ZERO) && (c <= ipv4dq_pkg::CH_NINE))
                        start_digits(c);
                    else
                        ps_failed = 1'b1;
                end
                ipv4dq_pkg::PH_NUM:
                begin
                    d = hex_value(c);
                    if (ps_pfx == ipv4dq_pkg::PFX_ZERO)
                    begin
                        if ((c == ipv4dq_pkg::CH_LX) || (c == ipv4dq_pkg::CH_UX))
                            ps_pfx = ipv4dq_pkg::PFX_ZX;
                        else if (d < 8)
                        begin
                            ps_base  = ipv4dq_pkg::BASE_OCT;
                            ps_pfx   = ipv4dq_pkg::PFX_BODY;
                            ps_value = 9'(d);
                        end
                        else
                            finish_number(c);
                    end
                    else if (ps_pfx == ipv4dq_pkg::PFX_ZX)
                    begin
                        if (d < 16)
                        begin
                            ps_base  = ipv4dq_pkg::BASE_HEX;
                            ps_pfx   = ipv4dq_pkg::PFX_BODY;
                            ps_value = 9'(d);
                        end
                        else
                            finish_number(c);
                    end
                    else
                    begin
                        radix = (ps_base == ipv4dq_pkg::BASE_HEX) ? 16 :
                                (ps_base == ipv4dq_pkg::BASE_OCT) ? 8 : 10;
                        if (d < radix)
                        begin
                            v = ps_value * radix + d;
                            if (v > 256)
                                v = 256;
                            ps_value = 9'(v);
                        end
                        else
                            finish_number(c);
                    end
                end
                ipv4dq_pkg::PH_TRAIL:
                begin
                    if (!blank_char(c))
                        ps_failed = 1'b1;
                end
                default:
                    ps_failed = 1'b1;
            endcase
            return;
        end

        ok   = 1'b0;
        last = 8'd0;
        if (ps_wild)
        begin
            ok = 1'b1;
            for (int i = 0; i < 3; i++)
                ps_octets[i] = 8'd0;
        end
        else if (!ps_failed && (ps_index == 2'd3))
        begin
            case (ps_phase)
                ipv4dq_pkg::PH_PRE:
                    ok = 1'b1;
                ipv4dq_pkg::PH_NUM:
                begin
                    ok   = (ps_pfx != ipv4dq_pkg::PFX_ZX) && !value_rejects();
                    last = ps_value[7:0];
                end
                ipv4dq_pkg::PH_TRAIL:
                begin
                    ok   = 1'b1;
                    last = ps_value[7:0];
                end
                default:
                    ok = 1'b0;
            endcase
        end
        res.accepted     = ok;
        res.octet_first  = ok ? ps_octets[0] : 8'd0;
        res.octet_second = ok ? ps_octets[1] : 8'd0;
        res.octet_third  = ok ? ps_octets[2] : 8'd0;
        res.octet_fourth = ok ? last : 8'd0;
        expected_q.push_back(res);
        parser_restart();
    endtask

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            draft_q.push_back(s[i]);
    endtask

    task automatic append_blanks(input int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(5);
            draft_q.push_back((r == 5) ? ipv4dq_pkg::CH_SPACE : 8'(ipv4dq_pkg::CH_TAB + r));
        end
    endtask

    task automatic commit_draft();
        foreach (draft_q[i])
            pending_q.push_back(draft_q[i]);
        pending_q.push_back(ipv4dq_pkg::CH_NUL);
        draft_q.delete();
    endtask

    task automatic push_string(input string s);
        append_text(s);
        commit_draft();
    endtask

    task automatic append_field(input int idx);
        int    v;
        int    sign_roll;
        string digits;
        if ((idx != 0) && ($urandom_range(7) == 0))
            append_blanks($urandom_range(1, 2));
        sign_roll = $urandom_range(19);
        if (sign_roll == 0)
            draft_q.push_back(ipv4dq_pkg::CH_PLUS);
        else if (sign_roll == 1)
            draft_q.push_back(ipv4dq_pkg::CH_MINUS);
        v = ($urandom_range(9) == 0) ? $urandom_range(256, 70000) : $urandom_range(255);
        if ((sign_roll == 1) && $urandom_range(1))
            v = 0;
        case ($urandom_range(11))
            0:
                digits = "";
            1, 2, 3, 4, 5:
                digits = $sformatf("%0d", v);
            6, 7:
                digits = $sformatf("0%0o", v);
            8, 9:
            begin
                digits = $sformatf("0x%0h", v);
                if ($urandom_range(1))
                    digits = digits.toupper();
            end
            10:
                digits = $sformatf("0%0d", $urandom_range(99));
            default:
                digits = "0";
        endcase
        append_text(digits);
    endtask

    task automatic push_random_string();
        int         kind;
        int         n;
        int         pos;
        logic [7:0] tricky;
        string      odd_chars;
        odd_chars = "x.+- 089afgX*";
        draft_q.delete();
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            n = $urandom_range(12);
            repeat (n)
                draft_q.push_back(8'($urandom_range(1, 255)));
        end
        else if (kind < 12)
        begin
            append_blanks($urandom_range(2));
            draft_q.push_back(ipv4dq_pkg::CH_STAR);
            n = $urandom_range(6);
            repeat (n)
                draft_q.push_back(8'($urandom_range(1, 255)));
        end
        else
        begin
            append_blanks(($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
            for (int f = 0; f < 4; f++)
            begin
                if (f != 0)
                    draft_q.push_back(ipv4dq_pkg::CH_DOT);
                append_field(f);
            end
            if ($urandom_range(4) == 0)
                append_blanks($urandom_range(1, 3));
            if (kind < 30)
            begin
                n = $urandom_range(1, 2);
                repeat (n)
                begin
                    pos = $urandom_range(draft_q.size());
                    if ($urandom_range(1))
                        tricky = 8'($urandom_range(1, 255));
                    else
                        tricky = odd_chars[$urandom_range(odd_chars.len() - 1)];
                    case ($urandom_range(2))
                        0:
                        begin
                            if (pos < draft_q.size())
                                draft_q[pos] = tricky;
                        end
                        1:
                        begin
                            if (pos < draft_q.size())
                                draft_q.delete(pos);
                        end
                        default:
                        begin
                            if (pos < draft_q.size())
                                draft_q.insert(pos, tricky);
                            else
                                draft_q.push_back(tricky);
                        end
                    endcase
                end
            end
        end
        commit_draft();
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // advance to the next byte once the current transaction is taken
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if ((pending_q.size() != 0) && ($urandom_range(99) >= send_idle))
            begin
                text_byte <= pending_q.pop_front();
                in_valid  <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // stall results at random, and hold them off for a long stretch once
    always @(negedge clk)
    begin
        if (!hold_done && (bytes_taken >= hold_at))
        begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left != 0)
            hold_left--;
        out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk)
    begin
        ipv4dq_pkg::result_t want;
        in_taken <= in_valid && !in_stall;
        if (in_valid && !in_stall)
        begin
            parse_byte(text_byte);
            bytes_taken++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: accepted=%0d octets=%0d.%0d.%0d.%0d", accepted,
                       octet_first, octet_second, octet_third, octet_fourth);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("accepted", 8'(want.accepted), 8'(accepted));
                check_field("octet_first", want.octet_first, octet_first);
                check_field("octet_second", want.octet_second, octet_second);
                check_field("octet_third", want.octet_third, octet_third);
                check_field("octet_fourth", want.octet_fourth, octet_fourth);
            end
        end
    end

    initial
    begin
        #3000000;
        $display("ipv4_dotted_quad_parser_unit_tb NOT OK");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        parser_restart();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 3; ph++)
        begin
            @(posedge clk);
            send_idle = (ph == 0) ? 14 : (ph == 1) ? 83 : 0;
            recv_idle = (ph == 0) ? 83 : (ph == 1) ? 14 : 0;
            if (ph == 0)
            begin
                push_string("");
                push_string("0.0.0.0");
                push_string("255.255.255.255");
                push_string(" \t192.168.1.1");
                push_string("*junk.9");
                push_string("1.2.3.256");
                push_string("1.2.3.-1");
                push_string("-0.+1.2.-0");
                push_string("0x7f.0377.0XFF.010");
                push_string("0x.1.1.1");
                push_string("08.1.1.1");
                push_string("1..2.");
                push_string("1.2.3. \t");
                push_string("1. .2.3");
                push_string("1.2.3.+");
                push_string("1.2.3.4 \n");
                push_string("1.2.3.4 x");
                push_string("1.2.3.4.5");
                push_string("99999.1.1.1");
                push_string("1.2.3");
                push_string("10.0xaB.0.1");
                push_string("1.2. 3.4");
            end
            if (ph == 2)
                hold_at = bytes_taken + 150;
            while (pending_q.size() < 530)
                push_random_string();
            wait ((pending_q.size() == 0) && !in_valid);
        end

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("ipv4_dotted_quad_parser_unit_tb OK");
        else
            $display("ipv4_dotted_quad_parser_unit_tb NOT OK");
        $finish;
    end

endmodule
